>>> rtl/lwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_pkg
// Shared types and codes for the LWE decryption inner-product block.
// ----------------------------------------------------------------------------
package lwe_pkg;

	localparam logic [1:0] OP_KEY = 2'd0;
	localparam logic [1:0] OP_VEC = 2'd1;
	localparam logic [1:0] OP_FIN = 2'd2;

	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_PLAIN   = 1'b1;

	localparam logic [31:0] MODULUS_RESET = 32'd4294967291;
	localparam logic [14:0] PLAIN_RESET   = 15'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [9:0]  index;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

>>> rtl/lwe_decrypt_inner_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_decrypt_inner_product
// LWE decryption: key store, modular inner product, rounding to plaintext.
// ----------------------------------------------------------------------------
// Items enter a two-deep queue and are executed one at a time. All modular
// reductions and the final rounding division go through one bit-serial
// divider, which sets the rate: a key load takes one reduction, a ciphertext
// vector element four reductions, and the scalar b three divisions, after
// which one plaintext item is presented. Items with opcode 3, and key or
// vector items with an index at or above MAX_DIMENSION, are accepted and
// dropped. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
module lwe_decrypt_inner_product #(
	parameter int MAX_DIMENSION = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [9:0]  element_index,
	input  logic [31:0] element_value,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [14:0] plaintext
);
	import lwe_pkg::*;

	logic [31:0] modulus_q;
	logic [14:0] plain_q;
	item_t       item_in;
	head_t       head;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			plain_q   <= PLAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODULUS) begin
				modulus_q <= cfg_data;
			end
			if (cfg_index == CFG_PLAIN) begin
				plain_q <= cfg_data[14:0];
			end
		end
	end

	assign item_in.opcode = opcode;
	assign item_in.index  = element_index;
	assign item_in.value  = element_value;

	lwe_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_in   (item_in),
		.pop       (pop),
		.head      (head)
	);

	lwe_back #(.MAX_DIMENSION(MAX_DIMENSION)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.modulus      (modulus_q),
		.plain_modulus(plain_q),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.plaintext    (plaintext)
	);

endmodule

>>> rtl/lwe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/lwe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_div
// Bit-serial restoring divider: 64-bit dividend, 33-bit divisor, one bit
// per cycle. Quotient and remainder are valid in the cycle done is high.
// ----------------------------------------------------------------------------
module lwe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo,
	output logic [32:0] rem
);

	logic [33:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shifted;
	logic        fits;

	assign shifted = {rem_q[32:0], quo_q[63]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[32:0];

endmodule

>>> rtl/lwe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_front
// Accepts items, drops those with no effect, and queues the rest (2 deep).
// ----------------------------------------------------------------------------
module lwe_front #(
	parameter int MAX_DIMENSION = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  lwe_pkg::item_t item_in,
	input  logic          pop,
	output lwe_pkg::head_t head
);
	import lwe_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       in_range;
	logic       keep;
	logic       push;
	logic       do_pop;

	assign in_range = 32'(item_in.index) < 32'(MAX_DIMENSION);
	assign keep = (item_in.opcode == OP_FIN) ||
		((item_in.opcode == OP_KEY || item_in.opcode == OP_VEC) && in_range);
	assign item_stall = count_q == 2'd2;
	assign push   = item_valid && !item_stall && keep;
	assign do_pop = pop && count_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	assign head.valid = count_q != 2'd0;
	assign head.item  = mem_q[rd_ptr_q];

endmodule

>>> rtl/lwe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_back
// Executes queued items: modular reduction, key store, multiply-accumulate
// and final rounding to the plaintext modulus. Holds the result register.
// ----------------------------------------------------------------------------
module lwe_back #(
	parameter int MAX_DIMENSION = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   modulus,
	input  logic [14:0]   plain_modulus,
	input  lwe_pkg::head_t head,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [14:0]   plaintext
);
	import lwe_pkg::*;

	localparam int AW = MAX_DIMENSION > 1 ? $clog2(MAX_DIMENSION) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_V_GO, S_V_WT, S_K_GO, S_K_WT, S_MUL_P, S_P_GO, S_P_WT,
		S_A_GO, S_A_WT, S_MUL_X, S_R_GO, S_R_WT, S_EMIT
	} state_t;

	state_t      state_q;
	item_t       item_q;
	logic [31:0] vr_q;
	logic [31:0] s_q;
	logic [31:0] x_q;
	logic [63:0] prod_q;
	logic [31:0] acc_q;
	logic [14:0] msg_q;
	logic        result_valid_q;
	logic [14:0] plaintext_q;

	logic [31:0] q;
	logic [14:0] t;
	logic        div_start;
	logic [63:0] div_num;
	logic [32:0] div_den;
	logic        div_done;
	logic [63:0] div_quo;
	logic [32:0] div_rem;
	logic [31:0] key_rdata;
	logic        ram_we;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [15:0] quo16;

	assign q = modulus < 32'd2 ? 32'd2 : modulus;
	assign t = plain_modulus < 15'd2 ? 15'd2 : plain_modulus;

	assign pop = state_q == S_IDLE && head.valid;
	assign ram_we = state_q == S_V_WT && div_done && item_q.opcode == OP_KEY;

	lwe_ram #(.WIDTH(32), .DEPTH(MAX_DIMENSION)) u_key (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(item_q.index)),
		.wdata(div_rem[31:0]),
		.re   (pop),
		.raddr(AW'(head.item.index)),
		.rdata(key_rdata)
	);

	always_comb begin
		div_start = 1'b0;
		div_num   = {32'd0, item_q.value};
		div_den   = {1'b0, q};
		case (state_q)
			S_V_GO: begin
				div_start = 1'b1;
			end
			S_K_GO: begin
				div_start = 1'b1;
				div_num   = {32'd0, key_rdata};
			end
			S_P_GO: begin
				div_start = 1'b1;
				div_num   = prod_q;
			end
			S_A_GO: begin
				div_start = 1'b1;
				div_num   = {32'd0, acc_q};
			end
			S_R_GO: begin
				div_start = 1'b1;
				div_num   = {prod_q[62:0], 1'b0} + {32'd0, q};
				div_den   = {q, 1'b0};
			end
			default: begin
			end
		endcase
	end

	lwe_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign mul_a = state_q == S_MUL_X ? x_q : s_q;
	assign mul_b = state_q == S_MUL_X ? {17'd0, t} : vr_q;
	assign sum   = {1'b0, div_rem[31:0]} + {1'b0, s_q};
	assign diff  = vr_q >= div_rem[31:0] ?
		{1'b0, vr_q} - {1'b0, div_rem[31:0]} :
		{1'b0, vr_q} + {1'b0, q} - {1'b0, div_rem[31:0]};
	assign quo16 = div_quo[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != S_EMIT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (head.valid) state_q <= S_V_GO;
				S_V_GO: state_q <= S_V_WT;
				S_V_WT: if (div_done) begin
					state_q <= item_q.opcode == OP_KEY ? S_IDLE :
						item_q.opcode == OP_VEC ? S_K_GO : S_A_GO;
				end
				S_K_GO: state_q <= S_K_WT;
				S_K_WT: if (div_done) state_q <= S_MUL_P;
				S_MUL_P: state_q <= S_P_GO;
				S_P_GO: state_q <= S_P_WT;
				S_P_WT: if (div_done) state_q <= S_A_GO;
				S_A_GO: state_q <= S_A_WT;
				S_A_WT: if (div_done) begin
					if (item_q.opcode == OP_VEC) begin
						acc_q   <= sum >= {1'b0, q} ? 32'(sum - {1'b0, q}) : sum[31:0];
						state_q <= S_IDLE;
					end else begin
						acc_q   <= '0;
						state_q <= S_MUL_X;
					end
				end
				S_MUL_X: state_q <= S_R_GO;
				S_R_GO: state_q <= S_R_WT;
				S_R_WT: if (div_done) state_q <= S_EMIT;
				S_EMIT: if (!result_valid_q || !result_stall) begin
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
		end
		if (state_q == S_V_WT && div_done) begin
			vr_q <= div_rem[31:0];
		end
		if ((state_q == S_K_WT || state_q == S_P_WT) && div_done) begin
			s_q <= div_rem[31:0];
		end
		if (state_q == S_A_WT && div_done) begin
			x_q <= diff[31:0];
		end
		if (state_q == S_MUL_P || state_q == S_MUL_X) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (state_q == S_R_WT && div_done) begin
			msg_q <= quo16 == {1'b0, t} ? 15'd0 : quo16[14:0];
		end
		if (state_q == S_EMIT && (!result_valid_q || !result_stall)) begin
			plaintext_q <= msg_q;
		end
	end

	assign result_valid = result_valid_q;
	assign plaintext    = plaintext_q;

endmodule
